/* design/efr_pkg.sv */
// Package with constants, state type and control structs of the escaped frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package efr_pkg;

    localparam int DEFAULT_PAYLOAD_DEPTH = 64;

    localparam logic [7:0] START_BYTE  = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESCAPE_MASK = 8'h20;
    localparam logic [7:0] SUM_GOOD    = 8'hFF;

    localparam logic [1:0] KIND_GOOD  = 2'd0;
    localparam logic [1:0] KIND_CSUM  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_API,
        S_BODY,
        S_SINGLE,
        S_READ,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic       begin_frame;
        logic       set_escape;
        logic       clear_escape;
        logic       load_len;
        logic       load_api;
        logic       add_sum;
        logic       store_byte;
        logic       dec_len;
        logic       load_kind;
        logic [1:0] kind;
        logic       rd_start;
        logic       rd_en;
        logic       rd_step;
        logic       draining;
        logic       single;
    } cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_escape;
        logic len_zero;
        logic sum_good;
        logic count_zero;
        logic last_read;
    } status_t;

endpackage
`default_nettype wire

/* design/efr_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* design/efr_datapath.sv */
// Datapath: unescaping, length and checksum registers, payload buffer and result fields.
`timescale 1ns / 1ps
`default_nettype none
module efr_datapath #(
    parameter int PAYLOAD_DEPTH = efr_pkg::DEFAULT_PAYLOAD_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      rx_byte,
    input  wire efr_pkg::cmd_t   cmd,
    output efr_pkg::status_t     status,
    output logic      [1:0]      event_kind,
    output logic      [7:0]      api_code,
    output logic      [6:0]      payload_length,
    output logic      [7:0]      data_byte,
    output logic                 data_valid,
    output logic                 last
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(PAYLOAD_DEPTH);

    logic          escape_reg, escape_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    api_reg, api_next;
    logic [7:0]    sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [1:0]    kind_reg, kind_next;

    logic [7:0]    plain_byte;
    logic [7:0]    sum_add;
    logic          ram_we;
    logic [7:0]    ram_rdata;

    assign plain_byte = escape_reg ? (rx_byte ^ efr_pkg::ESCAPE_MASK) : rx_byte;
    assign sum_add    = sum_reg + plain_byte;
    assign ram_we     = cmd.store_byte && (count_reg != FULL_COUNT);

    always_comb
    begin
        escape_next = escape_reg;
        len_next    = len_reg;
        api_next    = api_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        kind_next   = kind_reg;
        if (cmd.begin_frame)
        begin
            escape_next = 1'b0;
            sum_next    = 8'h00;
            count_next  = '0;
        end
        if (cmd.set_escape)
        begin
            escape_next = 1'b1;
        end
        if (cmd.clear_escape)
        begin
            escape_next = 1'b0;
        end
        // A zero length byte behaves as a length of one.
        if (cmd.load_len)
        begin
            len_next = (plain_byte == 8'h00) ? 8'h00 : plain_byte - 8'h01;
        end
        if (cmd.load_api)
        begin
            api_next = plain_byte;
        end
        if (cmd.add_sum)
        begin
            sum_next = sum_add;
        end
        if (ram_we)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.dec_len)
        begin
            len_next = len_reg - 8'h01;
        end
        if (cmd.load_kind)
        begin
            kind_next = cmd.kind;
        end
        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        if (cmd.rd_step)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
            len_reg    <= 8'h00;
            api_reg    <= 8'h00;
            sum_reg    <= 8'h00;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            kind_reg   <= efr_pkg::KIND_GOOD;
        end
        else
        begin
            escape_reg <= escape_next;
            len_reg    <= len_next;
            api_reg    <= api_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            kind_reg   <= kind_next;
        end
    end

    efr_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (plain_byte),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        status.is_start   = (rx_byte == efr_pkg::START_BYTE);
        status.is_escape  = (rx_byte == efr_pkg::ESCAPE_BYTE);
        status.len_zero   = (len_reg == 8'h00);
        status.sum_good   = (sum_add == efr_pkg::SUM_GOOD);
        status.count_zero = (count_reg == '0);
        status.last_read  = ((CW'(rd_idx_reg) + 1'b1) == count_reg);
    end

    // Error results carry zero in every field but the kind and last.
    assign event_kind     = kind_reg;
    assign api_code       = (kind_reg == efr_pkg::KIND_GOOD) ? api_reg : 8'h00;
    assign payload_length = (kind_reg == efr_pkg::KIND_GOOD) ? 7'(count_reg) : 7'd0;
    assign data_byte      = cmd.draining ? ram_rdata : 8'h00;
    assign data_valid     = cmd.draining;
    assign last           = cmd.single || (cmd.draining && status.last_read);

endmodule
`default_nettype wire

/* design/efr_controller.sv */
// Controller: frame parsing state machine and result sequencing.
`timescale 1ns / 1ps
`default_nettype none
module efr_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire efr_pkg::status_t  status,
    output efr_pkg::cmd_t          cmd
);

    efr_pkg::state_t state_reg, state_next;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= efr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        accept     = 1'b0;
        unique case (state_reg)
            efr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                accept   = in_valid;
                // Outside a frame, and after an error, only a start byte matters.
                if (accept && status.is_start)
                begin
                    cmd.begin_frame = 1'b1;
                    state_next      = efr_pkg::S_LEN;
                end
            end
            efr_pkg::S_LEN, efr_pkg::S_API, efr_pkg::S_BODY:
            begin
                in_ready = 1'b1;
                accept   = in_valid;
                if (accept)
                begin
                    priority if (status.is_start)
                    begin
                        cmd.load_kind = 1'b1;
                        cmd.kind      = efr_pkg::KIND_START;
                        state_next    = efr_pkg::S_SINGLE;
                    end
                    else if (status.is_escape)
                    begin
                        cmd.set_escape = 1'b1;
                    end
                    else
                    begin
                        cmd.clear_escape = 1'b1;
                        if (state_reg == efr_pkg::S_LEN)
                        begin
                            cmd.load_len = 1'b1;
                            state_next   = efr_pkg::S_API;
                        end
                        else if (state_reg == efr_pkg::S_API)
                        begin
                            cmd.load_api = 1'b1;
                            cmd.add_sum  = 1'b1;
                            state_next   = efr_pkg::S_BODY;
                        end
                        else if (!status.len_zero)
                        begin
                            cmd.add_sum    = 1'b1;
                            cmd.store_byte = 1'b1;
                            cmd.dec_len    = 1'b1;
                        end
                        else
                        begin
                            // Checksum byte closes the frame.
                            cmd.add_sum   = 1'b1;
                            cmd.load_kind = 1'b1;
                            cmd.kind      = status.sum_good ? efr_pkg::KIND_GOOD
                                                            : efr_pkg::KIND_CSUM;
                            if (!status.sum_good || status.count_zero)
                            begin
                                state_next = efr_pkg::S_SINGLE;
                            end
                            else
                            begin
                                cmd.rd_start = 1'b1;
                                state_next   = efr_pkg::S_READ;
                            end
                        end
                    end
                end
            end
            efr_pkg::S_SINGLE:
            begin
                out_valid  = 1'b1;
                cmd.single = 1'b1;
                if (out_ready)
                begin
                    state_next = efr_pkg::S_IDLE;
                end
            end
            efr_pkg::S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = efr_pkg::S_DRAIN;
            end
            efr_pkg::S_DRAIN:
            begin
                out_valid    = 1'b1;
                cmd.draining = 1'b1;
                if (out_ready)
                begin
                    if (status.last_read)
                    begin
                        state_next = efr_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_step = 1'b1;
                        state_next  = efr_pkg::S_READ;
                    end
                end
            end
            default:
            begin
                state_next = efr_pkg::S_IDLE;
            end
        endcase
    end

    // Input and output are never open in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    // A read is always followed by presenting its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> (state_reg == efr_pkg::S_DRAIN))
        else $error("read data not presented after read");

    // Delivering the final result of a run reopens the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && (cmd.single || status.last_read)) |=> in_ready)
        else $error("input not reopened after final result");

endmodule
`default_nettype wire

/* design/escaped_frame_receiver_core.sv */
// Escaped frame receiver: top level joining controller and datapath.
//
// Input channel (in_valid/in_ready, rx_byte) takes one raw serial byte per item.
// Frames are 0x7E, length, API code, payload, checksum; 0x7D escapes the next
// byte inside a frame. Output channel (out_valid/out_ready) gives results:
// one per stored payload byte of a good frame (last marks the final one), or a
// single result for an empty good frame, a checksum error or a start byte
// arriving mid-frame.
// Each byte that causes no result is absorbed with in_ready held high. After a checksum
// byte the first result is shown in the next cycle for a single result, or after the
// read state for a payload run; each payload result passes through the read state,
// set by the registered read port of the payload buffer, before it is shown.
// While results are pending in_ready is low, and a stalled receiver simply holds
// the current result; nothing is dropped.
// Reset returns the block to idle with the checksum and escape state cleared;
// the payload buffer is not cleared, as only entries written in the current
// frame are ever read.
`timescale 1ns / 1ps
`default_nettype none
module escaped_frame_receiver_core #(
    parameter int PAYLOAD_DEPTH = efr_pkg::DEFAULT_PAYLOAD_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [1:0] event_kind,
    output logic      [7:0] api_code,
    output logic      [6:0] payload_length,
    output logic      [7:0] data_byte,
    output logic            data_valid,
    output logic            last
);

    efr_pkg::cmd_t    cmd;
    efr_pkg::status_t status;

    efr_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    efr_datapath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .status         (status),
        .event_kind     (event_kind),
        .api_code       (api_code),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .last           (last)
    );

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the escaped frame receiver: byte stream in, frame events out.
`timescale 1ns / 1ps
module tb_top;

    localparam int DEPTH          = efr_pkg::DEFAULT_PAYLOAD_DEPTH;
    localparam int RESET_CYCLES   = 9;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_CYCLES   = 60;
    localparam int RANDOM_FRAMES  = 2;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] api;
        logic [6:0] plen;
        logic [7:0] data;
        logic       dvalid;
        logic       final_flag;
    } frame_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] event_kind;
    logic [7:0] api_code;
    logic [6:0] payload_length;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;

    logic [7:0]   send_q[$];
    frame_event_t expected_events[$];
    int           bytes_total = 0;
    int           bytes_taken = 0;
    int           mismatches = 0;
    int           cycle_no = 0;
    int           quiet_cycles = 0;
    int           idle_pct;
    int           stall_pct;

    // Receiver's own view of the frame being rebuilt
    int         frame_pos = 0;
    logic [7:0] bytes_left = 8'h00;
    logic [7:0] cur_api = 8'h00;
    logic [7:0] csum = 8'h00;
    logic       esc_armed = 1'b0;
    logic       discarding = 1'b0;
    logic [7:0] payload_buf [DEPTH];

    // Idle bytes, an empty frame, an escaped payload byte, a checksum error followed by
    // ignored bytes, a start byte straight after an escape, and recovery on the next start.
    logic [7:0] opening_seq [27] = '{
        8'h00, efr_pkg::ESCAPE_BYTE, 8'hFF,
        efr_pkg::START_BYTE, 8'h00, 8'hA5, 8'h5A,
        efr_pkg::START_BYTE, 8'h02, 8'h10, efr_pkg::ESCAPE_BYTE, 8'h5E, 8'h71,
        efr_pkg::START_BYTE, 8'h01, 8'h33, 8'h00, 8'h11, 8'h22,
        efr_pkg::START_BYTE, 8'h03, efr_pkg::ESCAPE_BYTE, efr_pkg::START_BYTE,
        efr_pkg::START_BYTE, 8'h01, 8'hFF, 8'h00
    };

    escaped_frame_receiver_core #(
        .PAYLOAD_DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .api_code      (api_code),
        .payload_length(payload_length),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Phases rotate: no idling, sender idle, receiver stalling, both.
    always_comb
    begin
        case ((cycle_no / PHASE_CYCLES) % 4)
            1:
            begin
                idle_pct  = 46;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 46;
            end
            3:
            begin
                idle_pct  = 22;
                stall_pct = 22;
            end
            default:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
        endcase
    end

    function automatic void absorb_rx_byte(input logic [7:0] raw);
        logic [7:0] b;
        int held;
        b = raw;
        if (discarding)
        begin
            if (b == efr_pkg::START_BYTE)
            begin
                discarding = 1'b0;
                frame_pos = 1;
                csum = 8'h00;
                esc_armed = 1'b0;
            end
            return;
        end
        if (frame_pos == 0)
        begin
            if (b == efr_pkg::START_BYTE)
            begin
                frame_pos = 1;
                csum = 8'h00;
                esc_armed = 1'b0;
            end
            return;
        end
        if (b == efr_pkg::START_BYTE)
        begin
            discarding = 1'b1;
            expected_events.push_back(frame_event_t'{efr_pkg::KIND_START, 8'h00, 7'd0,
                                                     8'h00, 1'b0, 1'b1});
            return;
        end
        if (b == efr_pkg::ESCAPE_BYTE)
        begin
            esc_armed = 1'b1;
            return;
        end
        if (esc_armed)
        begin
            b = b ^ efr_pkg::ESCAPE_MASK;
            esc_armed = 1'b0;
        end
        if (frame_pos == 1)
        begin
            // A length of zero behaves as a length of one.
            bytes_left = (b == 8'h00) ? 8'h00 : b - 8'h01;
            frame_pos = 2;
            return;
        end
        csum = csum + b;
        if (frame_pos == 2)
        begin
            cur_api = b;
            frame_pos = 3;
            return;
        end
        if (bytes_left != 8'h00)
        begin
            // Bytes past the end of the buffer still count towards the checksum.
            if (frame_pos - 3 < DEPTH)
            begin
                payload_buf[frame_pos - 3] = b;
                frame_pos++;
            end
            bytes_left = bytes_left - 8'h01;
            return;
        end
        held = frame_pos - 3;
        frame_pos = 0;
        if (csum != efr_pkg::SUM_GOOD)
        begin
            discarding = 1'b1;
            expected_events.push_back(frame_event_t'{efr_pkg::KIND_CSUM, 8'h00, 7'd0,
                                                     8'h00, 1'b0, 1'b1});
        end
        else if (held == 0)
        begin
            expected_events.push_back(frame_event_t'{efr_pkg::KIND_GOOD, cur_api, 7'd0,
                                                     8'h00, 1'b0, 1'b1});
        end
        else
        begin
            for (int i = 0; i < held; i++)
                expected_events.push_back(frame_event_t'{efr_pkg::KIND_GOOD, cur_api,
                                                         7'(held), payload_buf[i], 1'b1,
                                                         i == held - 1});
        end
        csum = 8'h00;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Bytes equal to the start or escape byte must go escaped; others but 0x5E and 0x5D sometimes do.
    function automatic void push_escaped(input logic [7:0] b);
        if (b == efr_pkg::START_BYTE || b == efr_pkg::ESCAPE_BYTE ||
            (b != 8'h5E && b != 8'h5D && $urandom_range(19) == 0))
        begin
            send_q.push_back(efr_pkg::ESCAPE_BYTE);
            send_q.push_back(b ^ efr_pkg::ESCAPE_MASK);
        end
        else
        begin
            send_q.push_back(b);
        end
    endfunction

    // Breaks the frame off with a start byte, sometimes straight after an escape.
    function automatic bit break_frame(input int idx, input int cut_at);
        if (idx != cut_at)
            return 1'b0;
        if ($urandom_range(1) == 1)
            send_q.push_back(efr_pkg::ESCAPE_BYTE);
        send_q.push_back(efr_pkg::START_BYTE);
        return 1'b1;
    endfunction

    task automatic queue_frame(input int n, input bit corrupt, input bit truncate);
        logic [7:0] api;
        logic [7:0] len_byte;
        logic [7:0] b;
        logic [7:0] sum;
        int cut_at;
        api = 8'($urandom_range(255));
        len_byte = (n == 0 && $urandom_range(1) == 0) ? 8'h00 : 8'(n + 1);
        cut_at = truncate ? int'($urandom_range(n + 2)) : -1;
        send_q.push_back(efr_pkg::START_BYTE);
        if (break_frame(0, cut_at))
            return;
        push_escaped(len_byte);
        if (break_frame(1, cut_at))
            return;
        push_escaped(api);
        sum = api;
        for (int i = 0; i < n; i++)
        begin
            if (break_frame(i + 2, cut_at))
                return;
            if ($urandom_range(7) == 0)
                b = ($urandom_range(1) == 1) ? efr_pkg::START_BYTE : efr_pkg::ESCAPE_BYTE;
            else
                b = 8'($urandom_range(255));
            push_escaped(b);
            sum = sum + b;
        end
        if (break_frame(n + 2, cut_at))
            return;
        b = efr_pkg::SUM_GOOD - sum;
        if (corrupt)
            b = b ^ (8'h01 << $urandom_range(7));
        push_escaped(b);
    endtask

    // Driver: holds a byte until it is taken, then offers the next unless idling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                absorb_rx_byte(rx_byte);
                bytes_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= send_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each taken result with the oldest expected event.
    always @(posedge clk)
    begin : monitor
        frame_event_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got kind %0d api 0x%0h",
                             $time, event_kind, api_code);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.kind, event_kind);
                    check_field("api_code", want.api, api_code);
                    check_field("payload_length", want.plen, payload_length);
                    check_field("data_byte", want.data, data_byte);
                    check_field("data_valid", want.dvalid, data_valid);
                    check_field("last", want.final_flag, last);
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int pick;
        int n;
        foreach (opening_seq[i])
            send_q.push_back(opening_seq[i]);
        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            // Stray bytes between frames are ignored while idle.
            if ($urandom_range(4) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    n = $urandom_range(255);
                    send_q.push_back((8'(n) == efr_pkg::START_BYTE) ? efr_pkg::ESCAPE_BYTE
                                                                    : 8'(n));
                end
            end
            pick = $urandom_range(99);
            // One frame fills the buffer and runs one byte past its end.
            if (f == 1)
                queue_frame(DEPTH + 1, 1'b0, 1'b0);
            else
            begin
                n = $urandom_range(0, 6);
                queue_frame(n, pick < 25, pick >= 25 && pick < 50);
            end
        end
        bytes_total = send_q.size();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        while ((bytes_taken < bytes_total || expected_events.size() != 0) && mismatches == 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
design/efr_pkg.sv
design/efr_ram.sv
design/efr_datapath.sv
design/efr_controller.sv
design/escaped_frame_receiver_core.sv
test/tb_top.sv
